// File: design/clt_pkg.sv
// Shared types, codes and constants for the command line tokenizer.
`timescale 1ns / 1ps

package clt_pkg;

	// Default line buffer length in bytes.
	localparam int LINE_MAX_DEF = 256;

	// Parser phase, one-hot.
	typedef enum logic [3:0] {
		PH_CMD     = 4'b0001,
		PH_ARGS    = 4'b0010,
		PH_CR      = 4'b0100,
		PH_INVALID = 4'b1000
	} phase_t;

	// Line status codes.
	localparam logic [1:0] ST_PENDING   = 2'd0;
	localparam logic [1:0] ST_VALID     = 2'd1;
	localparam logic [1:0] ST_INVALID   = 2'd2;
	localparam logic [1:0] ST_DISCARDED = 2'd3;

	// Token start codes.
	localparam logic [1:0] TOK_NONE = 2'd0;
	localparam logic [1:0] TOK_ARG1 = 2'd1;
	localparam logic [1:0] TOK_ARG2 = 2'd2;

	// Characters the parser reacts to.
	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_TAB   = 8'h09;

	// What one byte reports.
	typedef struct packed {
		logic [7:0] position;
		logic       is_terminator;
		logic [1:0] token_start;
		logic [1:0] line_status;
		logic       overflow;
	} result_t;

endpackage

// File: design/clt_step.sv
// Next-state and result logic for one byte of the command line tokenizer.
`timescale 1ns / 1ps

module clt_step #(
	parameter int LINE_MAX = clt_pkg::LINE_MAX_DEF,
	parameter int CNT_W    = $clog2(LINE_MAX + 1)
) (
	input  logic [7:0]            line_byte,
	input  clt_pkg::phase_t       phase,
	input  clt_pkg::phase_t       prior_phase,
	input  logic [CNT_W-1:0]      byte_count,
	input  logic                  first_arg_seen,
	output clt_pkg::phase_t       phase_nxt,
	output clt_pkg::phase_t       prior_phase_nxt,
	output logic [CNT_W-1:0]      byte_count_nxt,
	output logic                  first_arg_seen_nxt,
	output clt_pkg::result_t      result
);

	logic        ovf;
	logic        nul;
	logic        clear;
	logic [1:0]  tok;
	logic [1:0]  status;
	logic [15:0] cnt_ext;
	logic [CNT_W-1:0] cnt_inc;

	assign ovf     = (byte_count >= CNT_W'(LINE_MAX));
	assign cnt_ext = 16'(byte_count);
	assign cnt_inc = ovf ? byte_count : byte_count + CNT_W'(1);

	always_comb begin
		phase_nxt          = phase;
		prior_phase_nxt    = prior_phase;
		first_arg_seen_nxt = first_arg_seen;
		nul                = (line_byte == clt_pkg::CH_NUL);
		tok                = clt_pkg::TOK_NONE;
		status             = clt_pkg::ST_PENDING;
		clear              = 1'b0;

		unique case (phase)
			clt_pkg::PH_CMD: begin
				if (line_byte == clt_pkg::CH_SPACE) begin
					prior_phase_nxt = clt_pkg::PH_CMD;
					phase_nxt       = clt_pkg::PH_ARGS;
					nul             = 1'b1;
				end else if (line_byte == clt_pkg::CH_CR) begin
					phase_nxt = clt_pkg::PH_CR;
					nul       = 1'b1;
				end
			end
			clt_pkg::PH_ARGS: begin
				if (line_byte != clt_pkg::CH_SPACE && line_byte != clt_pkg::CH_TAB &&
				    line_byte != clt_pkg::CH_CR && prior_phase == clt_pkg::PH_CMD) begin
					tok                = first_arg_seen ? clt_pkg::TOK_ARG2 : clt_pkg::TOK_ARG1;
					first_arg_seen_nxt = 1'b1;
					prior_phase_nxt    = clt_pkg::PH_ARGS;
				end else if (line_byte == clt_pkg::CH_SPACE &&
				             prior_phase == clt_pkg::PH_ARGS) begin
					prior_phase_nxt = clt_pkg::PH_CMD;
					nul             = 1'b1;
				end else if (line_byte == clt_pkg::CH_CR) begin
					prior_phase_nxt = clt_pkg::PH_ARGS;
					phase_nxt       = clt_pkg::PH_CR;
				end
			end
			clt_pkg::PH_CR: begin
				if (line_byte == clt_pkg::CH_LF) begin
					if (prior_phase == clt_pkg::PH_INVALID) begin
						status = clt_pkg::ST_DISCARDED;
					end else begin
						status = clt_pkg::ST_VALID;
						nul    = 1'b1;
					end
					phase_nxt          = clt_pkg::PH_CMD;
					first_arg_seen_nxt = 1'b0;
					clear              = 1'b1;
				end else begin
					phase_nxt = clt_pkg::PH_INVALID;
					status    = clt_pkg::ST_INVALID;
				end
				prior_phase_nxt = clt_pkg::PH_CR;
			end
			default: begin
				// Invalid line: wait for the CR that ends it.
				prior_phase_nxt = clt_pkg::PH_INVALID;
				if (line_byte == clt_pkg::CH_CR) begin
					phase_nxt = clt_pkg::PH_CR;
				end else begin
					phase_nxt = clt_pkg::PH_INVALID;
					status    = clt_pkg::ST_INVALID;
				end
			end
		endcase
	end

	assign byte_count_nxt = clear ? '0 : cnt_inc;

	always_comb begin
		result.position      = (cnt_ext > 16'd255) ? 8'hFF : cnt_ext[7:0];
		result.is_terminator = nul && !ovf;
		result.token_start   = tok;
		result.line_status   = status;
		result.overflow      = ovf;
	end

endmodule

// File: design/command_line_tokenizer.sv
// Top level of the command line tokenizer: byte register, parser state and result register.
`timescale 1ns / 1ps
//
// The block parses a CRLF-terminated command line, one byte per item on the
// input channel (in_valid, in_ready, line_byte). For every byte it returns one
// item on the output channel (out_valid, out_ready and the result fields):
// the byte's offset in the line, whether the stored line holds a NUL there,
// whether the byte starts argument one or two, the line status and an
// overflow flag once the line runs past LINE_MAX bytes.
// An accepted byte sits in the input register, where the parser logic
// evaluates it against the phase registers; the result and the updated
// phase are then written together, so a result is offered from the result
// register. One byte per cycle is sustained while the receiver does not
// stall, as each byte updates the phase registers before the next.
// When the receiver stalls, the result register holds its item and the input
// register keeps one more byte; in_ready falls only when both are full.
// Reset clears both valid flags, puts the parser in the command word phase
// and zeroes the byte count and the first-argument flag.
//
module command_line_tokenizer #(
	parameter int LINE_MAX = clt_pkg::LINE_MAX_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] line_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] position,
	output logic       is_terminator,
	output logic [1:0] token_start,
	output logic [1:0] line_status,
	output logic       overflow
);

	localparam int CNT_W = $clog2(LINE_MAX + 1);

	// Input register stage.
	logic       valid_s1;
	logic [7:0] byte_s1;

	// Result register stage.
	logic             valid_s2;
	clt_pkg::result_t result_s2;

	// Parser state, advanced once per byte as it moves into the result stage.
	clt_pkg::phase_t  phase_q;
	clt_pkg::phase_t  prior_phase_q;
	logic [CNT_W-1:0] byte_count_q;
	logic             first_arg_seen_q;

	clt_pkg::phase_t  phase_nxt;
	clt_pkg::phase_t  prior_phase_nxt;
	logic [CNT_W-1:0] byte_count_nxt;
	logic             first_arg_seen_nxt;
	clt_pkg::result_t result_nxt;

	logic advance;

	// A byte moves on whenever the result slot is free or is being emptied.
	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	clt_step #(
		.LINE_MAX (LINE_MAX),
		.CNT_W    (CNT_W)
	) u_step (
		.line_byte          (byte_s1),
		.phase              (phase_q),
		.prior_phase        (prior_phase_q),
		.byte_count         (byte_count_q),
		.first_arg_seen     (first_arg_seen_q),
		.phase_nxt          (phase_nxt),
		.prior_phase_nxt    (prior_phase_nxt),
		.byte_count_nxt     (byte_count_nxt),
		.first_arg_seen_nxt (first_arg_seen_nxt),
		.result             (result_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= line_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q          <= clt_pkg::PH_CMD;
			prior_phase_q    <= clt_pkg::PH_CMD;
			byte_count_q     <= '0;
			first_arg_seen_q <= 1'b0;
		end else if (advance) begin
			phase_q          <= phase_nxt;
			prior_phase_q    <= prior_phase_nxt;
			byte_count_q     <= byte_count_nxt;
			// A completed line, valid or discarded, starts over without arguments.
			first_arg_seen_q <= first_arg_seen_nxt;
		end
	end

	assign out_valid     = valid_s2;
	assign position      = result_s2.position;
	assign is_terminator = result_s2.is_terminator;
	assign token_start   = result_s2.token_start;
	assign line_status   = result_s2.line_status;
	assign overflow      = result_s2.overflow;

endmodule
